// ===== rtl/lccp_pkg.sv =====
// Shared constants and types of the coefficient compress, pack and compare block.
package lccp_pkg;

   localparam int unsigned LANES       = 4;
   localparam int unsigned COEFF_W     = 13;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned NUM_BYTES   = 5;
   localparam int unsigned QUANT_W     = 10;
   localparam int unsigned MULT_K_W    = 21;
   localparam int unsigned PROD_W      = WORD_W + MULT_K_W;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [WORD_W-1:0]   KYBER_Q   = 32'd3329;
   localparam logic [MULT_K_W-1:0] RECIP_D10 = 21'd1290167;
   localparam logic [MULT_K_W-1:0] RECIP_D4  = 21'd80635;
   localparam logic [WORD_W-1:0]   ROUND_D10 = 32'd1665;
   localparam logic [WORD_W-1:0]   ROUND_D4  = 32'd26640;

   localparam logic [1:0] OP_PACK_D10 = 2'd0;
   localparam logic [1:0] OP_CMP_D10  = 2'd1;
   localparam logic [1:0] OP_PACK_D4  = 2'd2;
   localparam logic [1:0] OP_CMP_D4   = 2'd3;

   localparam logic [2:0] BYTES_D10 = 3'd5;
   localparam logic [2:0] BYTES_D4  = 3'd2;

   // One classified item as it waits between the front and the back.
   typedef struct packed {
      logic [LANES-1:0][WORD_W-1:0] dividend;
      logic                         is_d4;
      logic                         is_cmp;
      logic                         last;
      logic [NUM_BYTES-1:0][7:0]    expected;
   } entry_type;

endpackage

// ===== rtl/lattice_coeff_compress_pack_compare_top.sv =====
// Top level of the coefficient compress, pack and compare block.
// The block takes one group of four coefficients per cycle while req_stall is low, and
// returns one result item per group, in order. A group passes through the input queue,
// then the register of the four lane multipliers that do the rounding multiply-high, then
// the output register where packing, the compare and the sticky mismatch flag are settled.
// The sustained rate is one item per cycle while rsp_stall is low; the queue of QUEUE_DEPTH
// items absorbs output stalls, and req_stall rises only when it is full.
module lattice_coeff_compress_pack_compare_top #(
   parameter int unsigned QUEUE_DEPTH = lccp_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_opcode,
   input  logic signed [12:0]           req_coeff_0,
   input  logic signed [12:0]           req_coeff_1,
   input  logic signed [12:0]           req_coeff_2,
   input  logic signed [12:0]           req_coeff_3,
   input  logic [7:0]                   req_expect_byte_0,
   input  logic [7:0]                   req_expect_byte_1,
   input  logic [7:0]                   req_expect_byte_2,
   input  logic [7:0]                   req_expect_byte_3,
   input  logic [7:0]                   req_expect_byte_4,
   input  logic                         req_group_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_out_byte_0,
   output logic [7:0]                   rsp_out_byte_1,
   output logic [7:0]                   rsp_out_byte_2,
   output logic [7:0]                   rsp_out_byte_3,
   output logic [7:0]                   rsp_out_byte_4,
   output logic [2:0]                   rsp_byte_count,
   output logic                         rsp_mismatch,
   output logic                         rsp_poly_done
);

   logic [lccp_pkg::LANES-1:0][lccp_pkg::COEFF_W-1:0] coeff;
   logic [lccp_pkg::NUM_BYTES-1:0][7:0]               expected;
   logic [lccp_pkg::NUM_BYTES-1:0][7:0]               rsp_bytes;
   lccp_pkg::entry_type                               front_entry;
   lccp_pkg::entry_type                               queue_entry;
   logic                                              queue_valid;
   logic                                              back_ready;

   assign coeff    = {req_coeff_3, req_coeff_2, req_coeff_1, req_coeff_0};
   assign expected = {req_expect_byte_4, req_expect_byte_3, req_expect_byte_2,
                      req_expect_byte_1, req_expect_byte_0};

   lccp_front u_front (
      .opcode     (req_opcode),
      .coeff      (coeff),
      .expected   (expected),
      .group_last (req_group_last),
      .entry      (front_entry)
   );

   lccp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_stall (req_stall),
      .push_entry (front_entry),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_entry  (queue_entry)
   );

   lccp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .entry_valid    (queue_valid),
      .entry_ready    (back_ready),
      .entry          (queue_entry),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bytes      (rsp_bytes),
      .rsp_byte_count (rsp_byte_count),
      .rsp_mismatch   (rsp_mismatch),
      .rsp_poly_done  (rsp_poly_done)
   );

   assign rsp_out_byte_0 = rsp_bytes[0];
   assign rsp_out_byte_1 = rsp_bytes[1];
   assign rsp_out_byte_2 = rsp_bytes[2];
   assign rsp_out_byte_3 = rsp_bytes[3];
   assign rsp_out_byte_4 = rsp_bytes[4];

endmodule

// ===== rtl/lccp_front.sv =====
// Front end: decodes the opcode and forms the rounding dividend of each coefficient.
module lccp_front (
   input  logic [1:0]                                         opcode,
   input  logic [lccp_pkg::LANES-1:0][lccp_pkg::COEFF_W-1:0]  coeff,
   input  logic [lccp_pkg::NUM_BYTES-1:0][7:0]                expected,
   input  logic                                               group_last,
   output lccp_pkg::entry_type                                entry
);

   logic                          is_d4;
   logic                          is_cmp;
   logic [lccp_pkg::LANES-1:0][lccp_pkg::WORD_W-1:0] pos_word;

   always_comb begin
      unique case (opcode)
         lccp_pkg::OP_PACK_D10: begin
            is_d4  = 1'b0;
            is_cmp = 1'b0;
         end
         lccp_pkg::OP_CMP_D10: begin
            is_d4  = 1'b0;
            is_cmp = 1'b1;
         end
         lccp_pkg::OP_PACK_D4: begin
            is_d4  = 1'b1;
            is_cmp = 1'b0;
         end
         default: begin
            is_d4  = 1'b1;
            is_cmp = 1'b1;
         end
      endcase
   end

   // A negative coefficient gets q added; one below -q stays negative and
   // then wraps as a 32-bit word, unlike the in-range values.
   always_comb begin
      for (int i = 0; i < lccp_pkg::LANES; i++) begin
         pos_word[i] = {{(lccp_pkg::WORD_W - lccp_pkg::COEFF_W){coeff[i][lccp_pkg::COEFF_W-1]}},
                        coeff[i]};
         if (coeff[i][lccp_pkg::COEFF_W-1]) begin
            pos_word[i] = pos_word[i] + lccp_pkg::KYBER_Q;
         end
         if (is_d4) begin
            entry.dividend[i] = {pos_word[i][lccp_pkg::WORD_W-9:0], 8'b0} + lccp_pkg::ROUND_D4;
         end else begin
            entry.dividend[i] = {pos_word[i][lccp_pkg::WORD_W-11:0], 10'b0}
                              + lccp_pkg::ROUND_D10;
         end
      end
      entry.is_d4    = is_d4;
      entry.is_cmp   = is_cmp;
      entry.last     = group_last;
      entry.expected = expected;
   end

endmodule

// ===== rtl/lccp_queue.sv =====
// Short queue of classified items between the front end and the back end.
module lccp_queue #(
   parameter int unsigned DEPTH = lccp_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_stall,
   input  lccp_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output lccp_pkg::entry_type pop_entry
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   lccp_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_stall = (count_ff == CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && !push_stall;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/lccp_back.sv =====
// Back end: multiply-high rounding, bit packing, compare and the sticky mismatch flag.
module lccp_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              entry_valid,
   output logic                              entry_ready,
   input  lccp_pkg::entry_type               entry,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lccp_pkg::NUM_BYTES-1:0][7:0] rsp_bytes,
   output logic [2:0]                        rsp_byte_count,
   output logic                              rsp_mismatch,
   output logic                              rsp_poly_done
);

   // Multiply stage.
   logic                                               s1_valid_ff, s1_valid_in;
   logic [lccp_pkg::LANES-1:0][lccp_pkg::QUANT_W-1:0]  quant_ff, quant_in;
   logic                                               s1_d4_ff;
   logic                                               s1_cmp_ff;
   logic                                               s1_last_ff;
   logic [lccp_pkg::NUM_BYTES-1:0][7:0]                s1_expected_ff;
   logic [lccp_pkg::PROD_W-1:0]                        prod [lccp_pkg::LANES];
   logic [lccp_pkg::MULT_K_W-1:0]                      recip;

   // Output stage.
   logic                                  out_valid_ff, out_valid_in;
   logic [lccp_pkg::NUM_BYTES-1:0][7:0]   bytes_ff, bytes_in;
   logic [2:0]                            count_ff, count_in;
   logic                                  mismatch_ff, mismatch_in;
   logic                                  done_ff;
   logic                                  sticky_ff, sticky_in;
   logic                                  out_ready;
   logic                                  s1_load;
   logic                                  out_load;
   logic                                  differs;

   assign out_ready   = !out_valid_ff || !rsp_stall;
   assign entry_ready = !s1_valid_ff || out_ready;
   assign s1_load     = entry_valid && entry_ready;
   assign out_load    = s1_valid_ff && out_ready;

   // The rounded value sits in bits 41..32 of the product; d=4 keeps the low nibble.
   always_comb begin
      recip = entry.is_d4 ? lccp_pkg::RECIP_D4 : lccp_pkg::RECIP_D10;
      for (int i = 0; i < lccp_pkg::LANES; i++) begin
         prod[i] = lccp_pkg::PROD_W'(entry.dividend[i]) * lccp_pkg::PROD_W'(recip);
         quant_in[i] = prod[i][lccp_pkg::WORD_W + lccp_pkg::QUANT_W - 1:lccp_pkg::WORD_W];
      end
      if (entry_ready) begin
         s1_valid_in = entry_valid;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      bytes_in = '0;
      if (s1_d4_ff) begin
         bytes_in[0] = {quant_ff[1][3:0], quant_ff[0][3:0]};
         bytes_in[1] = {quant_ff[3][3:0], quant_ff[2][3:0]};
         count_in    = lccp_pkg::BYTES_D4;
         differs     = ((bytes_in[0] ^ s1_expected_ff[0]) | (bytes_in[1] ^ s1_expected_ff[1]))
                       != 8'd0;
      end else begin
         bytes_in[0] = quant_ff[0][7:0];
         bytes_in[1] = {quant_ff[1][5:0], quant_ff[0][9:8]};
         bytes_in[2] = {quant_ff[2][3:0], quant_ff[1][9:6]};
         bytes_in[3] = {quant_ff[3][1:0], quant_ff[2][9:4]};
         bytes_in[4] = quant_ff[3][9:2];
         count_in    = lccp_pkg::BYTES_D10;
         differs     = (bytes_in ^ s1_expected_ff) != '0;
      end
      mismatch_in = sticky_ff || (s1_cmp_ff && differs);
      // The flag seen by the item marked last includes it; then the next polynomial starts clean.
      sticky_in   = s1_last_ff ? 1'b0 : mismatch_in;
      if (out_ready) begin
         out_valid_in = s1_valid_ff;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sticky_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (out_load) begin
            sticky_ff <= sticky_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         quant_ff       <= quant_in;
         s1_d4_ff       <= entry.is_d4;
         s1_cmp_ff      <= entry.is_cmp;
         s1_last_ff     <= entry.last;
         s1_expected_ff <= entry.expected;
      end
      if (out_load) begin
         bytes_ff    <= bytes_in;
         count_ff    <= count_in;
         mismatch_ff <= mismatch_in;
         done_ff     <= s1_last_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_bytes      = bytes_ff;
   assign rsp_byte_count = count_ff;
   assign rsp_mismatch   = mismatch_ff;
   assign rsp_poly_done  = done_ff;

endmodule

// ===== rtl/lccp_checker.sv =====
// Port-level checks of the compress, pack and compare block, bound to its top level.
module lccp_port_checks (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte_0,
   input logic [7:0] rsp_out_byte_1,
   input logic [7:0] rsp_out_byte_2,
   input logic [7:0] rsp_out_byte_3,
   input logic [7:0] rsp_out_byte_4,
   input logic [2:0] rsp_byte_count,
   input logic       rsp_mismatch,
   input logic       rsp_poly_done
);

   // A stalled result item stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte_0)
         && $stable(rsp_out_byte_1) && $stable(rsp_out_byte_2)
         && $stable(rsp_out_byte_3) && $stable(rsp_out_byte_4)
         && $stable(rsp_byte_count) && $stable(rsp_mismatch) && $stable(rsp_poly_done))
      else $error("result item changed while stalled");

   // Only the two packing widths exist.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count == lccp_pkg::BYTES_D10)
                 || (rsp_byte_count == lccp_pkg::BYTES_D4))
      else $error("byte count is neither the d10 nor the d4 count");

   // A d4 item leaves the upper three bytes clear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_count == lccp_pkg::BYTES_D4)
         |-> (rsp_out_byte_2 == 8'd0) && (rsp_out_byte_3 == 8'd0) && (rsp_out_byte_4 == 8'd0))
      else $error("d4 item carries data in bytes two to four");

   // Nothing is offered right after reset.
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind lattice_coeff_compress_pack_compare_top lccp_port_checks u_lccp_port_checks (.*);
